[design/bbas_pkg.sv]
// shared constants, types and helper functions of the bitmap block allocator store
`timescale 1ns / 1ps

package bbas_pkg;

    localparam int NUM_BLOCKS      = 512;
    localparam int BLOCK_BYTES     = 32;
    localparam int MAP_FIRST_BLOCK = 0;
    localparam int MAP_BLOCK_COUNT = 2;

    localparam int WORDS_PER_BLOCK = BLOCK_BYTES / 8;
    localparam int WORD_W          = $clog2(WORDS_PER_BLOCK);
    localparam int BLK_W           = $clog2(NUM_BLOCKS);
    localparam int MEM_DEPTH       = NUM_BLOCKS * WORDS_PER_BLOCK;
    localparam int MEM_AW          = BLK_W + WORD_W;
    localparam int ROW_BITS        = (NUM_BLOCKS < 32) ? NUM_BLOCKS : 32;
    localparam int BIT_W           = $clog2(ROW_BITS);
    localparam int MAP_ROWS        = NUM_BLOCKS / ROW_BITS;
    localparam int ROW_W           = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
    localparam int CNT_W           = $clog2(NUM_BLOCKS + 1);
    localparam int MAP_INIT_USED   = (MAP_FIRST_BLOCK + MAP_BLOCK_COUNT > NUM_BLOCKS) ?
                                     (NUM_BLOCKS - MAP_FIRST_BLOCK) : MAP_BLOCK_COUNT;

    // beat field widths
    localparam int OPCODE_W  = 3;
    localparam int BLKNUM_W  = 10;
    localparam int WIDX_W    = 2;
    localparam int DATA_W    = 64;
    localparam int STATUS_W  = 2;
    localparam int GRANT_W   = 9;
    localparam int RIDX_W    = 2;
    localparam int COUNT_W   = 10;

    localparam logic [OPCODE_W-1:0] OP_ALLOC   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_REQUEST = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_RELEASE = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_WRITE   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_READ    = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_USED    = 2'd3
    } t_status;

    typedef struct packed {
        logic        req_ready;
        logic        lookup;
        logic        lookup_free;
        logic        alloc;
        logic        map_set;
        logic        map_clr;
        logic        mem_wr;
        logic        mem_rd;
        logic        word_clr;
        logic        word_inc;
        logic        rsp_load;
        t_status     rsp_status;
        logic        rsp_grant;
        logic        rsp_data;
        logic        rsp_last;
    } t_cmd;

    typedef struct packed {
        logic                req_valid;
        logic [OPCODE_W-1:0] opcode;
        logic                blk_ok;
        logic                map_bit;
        logic                map_full;
        logic                last_word;
        logic                rsp_free;
    } t_sts;

    function automatic logic [ROW_BITS-1:0] map_reset_row(input int row);
        logic [ROW_BITS-1:0] bits;
        int                  blk;
        bits = '0;
        for (int b = 0; b < ROW_BITS; b++) begin
            blk = row * ROW_BITS + b;
            bits[b] = (blk >= MAP_FIRST_BLOCK) && (blk < MAP_FIRST_BLOCK + MAP_BLOCK_COUNT);
        end
        return bits;
    endfunction

    // lowest clear bit of a map row
    function automatic logic [BIT_W-1:0] first_free_bit(input logic [ROW_BITS-1:0] bits);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (!bits[i]) idx = BIT_W'(i);
        end
        return idx;
    endfunction

    // lowest row that is not full
    function automatic logic [ROW_W-1:0] first_free_row(input logic [MAP_ROWS-1:0] full);
        logic [ROW_W-1:0] idx;
        idx = '0;
        for (int i = MAP_ROWS - 1; i >= 0; i--) begin
            if (!full[i]) idx = ROW_W'(i);
        end
        return idx;
    endfunction

endpackage

[design/bbas_req_if.sv]
// request channel: opcode, block number, word index and write data
`timescale 1ns / 1ps

interface bbas_req_if;
    logic                          valid;
    logic                          ready;
    logic [bbas_pkg::OPCODE_W-1:0] opcode;
    logic [bbas_pkg::BLKNUM_W-1:0] block_number;
    logic [bbas_pkg::WIDX_W-1:0]   word_index;
    logic [bbas_pkg::DATA_W-1:0]   write_word;

    modport source (output valid, opcode, block_number, word_index, write_word, input ready);
    modport sink (input valid, opcode, block_number, word_index, write_word, output ready);
endinterface

[design/bbas_rsp_if.sv]
// response channel: status, grant, read data and block counts
`timescale 1ns / 1ps

interface bbas_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bbas_pkg::STATUS_W-1:0] status;
    logic [bbas_pkg::GRANT_W-1:0]  granted_block;
    logic [bbas_pkg::DATA_W-1:0]   read_word;
    logic [bbas_pkg::RIDX_W-1:0]   read_index;
    logic                          last;
    logic [bbas_pkg::COUNT_W-1:0]  used_blocks;
    logic [bbas_pkg::COUNT_W-1:0]  free_blocks;

    modport source (output valid, status, granted_block, read_word, read_index, last,
                    used_blocks, free_blocks, input ready);
    modport sink (input valid, status, granted_block, read_word, read_index, last,
                  used_blocks, free_blocks, output ready);
endinterface

[design/bbas_ctrl.sv]
// controller state machine sequencing lookup, update and read bursts
`timescale 1ns / 1ps

module bbas_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bbas_pkg::t_sts  i_sts,
    output bbas_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_LOOKUP   = 5'b00010,
        S_EXEC     = 5'b00100,
        S_RD_ISSUE = 5'b01000,
        S_RD_EMIT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rsp_status = bbas_pkg::ST_OK;
        case (r_state)
            S_IDLE: begin
                o_cmd.req_ready = 1'b1;
                if (i_sts.req_valid) n_state = S_LOOKUP;
            end
            S_LOOKUP: begin
                o_cmd.lookup      = 1'b1;
                o_cmd.lookup_free = (i_sts.opcode == bbas_pkg::OP_ALLOC);
                n_state           = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.rsp_free) begin
                    o_cmd.rsp_load = 1'b1;
                    o_cmd.rsp_last = 1'b1;
                    n_state        = S_IDLE;
                    case (i_sts.opcode)
                        bbas_pkg::OP_ALLOC: begin
                            if (i_sts.map_full) begin
                                o_cmd.rsp_status = bbas_pkg::ST_FULL;
                            end else begin
                                o_cmd.alloc     = 1'b1;
                                o_cmd.rsp_grant = 1'b1;
                            end
                        end
                        bbas_pkg::OP_REQUEST: begin
                            if (!i_sts.blk_ok) begin
                                o_cmd.rsp_status = bbas_pkg::ST_INVALID;
                            end else if (i_sts.map_bit) begin
                                o_cmd.rsp_status = bbas_pkg::ST_USED;
                            end else begin
                                o_cmd.map_set = 1'b1;
                            end
                        end
                        bbas_pkg::OP_RELEASE: begin
                            if (!i_sts.blk_ok) begin
                                o_cmd.rsp_status = bbas_pkg::ST_INVALID;
                            end else begin
                                o_cmd.map_clr = i_sts.map_bit;
                            end
                        end
                        bbas_pkg::OP_WRITE: begin
                            if (!i_sts.blk_ok) begin
                                o_cmd.rsp_status = bbas_pkg::ST_INVALID;
                            end else begin
                                o_cmd.mem_wr = 1'b1;
                            end
                        end
                        bbas_pkg::OP_READ: begin
                            if (!i_sts.blk_ok) begin
                                o_cmd.rsp_status = bbas_pkg::ST_INVALID;
                            end else begin
                                o_cmd.rsp_load = 1'b0;
                                o_cmd.rsp_last = 1'b0;
                                o_cmd.word_clr = 1'b1;
                                n_state        = S_RD_ISSUE;
                            end
                        end
                        default: begin
                            o_cmd.rsp_status = bbas_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            S_RD_ISSUE: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_RD_EMIT;
            end
            S_RD_EMIT: begin
                if (i_sts.rsp_free) begin
                    o_cmd.rsp_load = 1'b1;
                    o_cmd.rsp_data = 1'b1;
                    o_cmd.rsp_last = i_sts.last_word;
                    o_cmd.word_inc = 1'b1;
                    n_state        = i_sts.last_word ? S_IDLE : S_RD_ISSUE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[design/bbas_dp.sv]
// datapath: request register, used map rows, block memory, counters and output register
`timescale 1ns / 1ps

module bbas_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bbas_req_if.sink        i_req,
    bbas_rsp_if.source      o_rsp,
    input  bbas_pkg::t_cmd  i_cmd,
    output bbas_pkg::t_sts  o_sts
);

    logic [bbas_pkg::OPCODE_W-1:0]  r_opcode;
    logic [bbas_pkg::BLKNUM_W-1:0]  r_block_number;
    logic [bbas_pkg::WIDX_W-1:0]    r_word_index;
    logic [bbas_pkg::DATA_W-1:0]    r_write_word;

    logic [bbas_pkg::ROW_BITS-1:0]  r_map [bbas_pkg::MAP_ROWS];
    logic [bbas_pkg::MAP_ROWS-1:0]  r_full;
    logic [bbas_pkg::ROW_W-1:0]     r_row_idx;
    logic [bbas_pkg::ROW_BITS-1:0]  r_row_bits;
    logic [bbas_pkg::CNT_W-1:0]     r_used;
    logic [bbas_pkg::CNT_W-1:0]     n_used;

    logic [bbas_pkg::DATA_W-1:0]    r_mem [bbas_pkg::MEM_DEPTH];
    logic [bbas_pkg::DATA_W-1:0]    r_mem_q;
    logic [bbas_pkg::WORD_W-1:0]    r_word_cnt;

    logic                           r_rsp_valid;
    logic [bbas_pkg::STATUS_W-1:0]  r_rsp_status;
    logic [bbas_pkg::GRANT_W-1:0]   r_rsp_grant;
    logic [bbas_pkg::DATA_W-1:0]    r_rsp_word;
    logic [bbas_pkg::RIDX_W-1:0]    r_rsp_index;
    logic                           r_rsp_last;
    logic [bbas_pkg::COUNT_W-1:0]   r_rsp_used;
    logic [bbas_pkg::COUNT_W-1:0]   r_rsp_free;

    logic                           req_fire;
    logic                           rsp_free;
    logic [bbas_pkg::BLK_W-1:0]     blk;
    logic [bbas_pkg::ROW_W-1:0]     blk_row;
    logic [bbas_pkg::BIT_W-1:0]     blk_bit;
    logic [bbas_pkg::BIT_W-1:0]     free_bit;
    logic [bbas_pkg::ROW_BITS-1:0]  n_row_bits;
    logic [bbas_pkg::BLK_W-1:0]     grant_blk;
    logic [bbas_pkg::CNT_W-1:0]     free_cnt;
    logic                           map_wr;

    function automatic logic [bbas_pkg::ROW_W-1:0] ROW_SEL(input logic [bbas_pkg::BLK_W-1:0] b);
        return bbas_pkg::ROW_W'(b >> bbas_pkg::BIT_W);
    endfunction

    assign req_fire    = i_req.valid && i_req.ready;
    assign rsp_free    = !r_rsp_valid || o_rsp.ready;
    assign i_req.ready = i_cmd.req_ready && i_rst_n;

    assign blk       = r_block_number[bbas_pkg::BLK_W-1:0];
    assign blk_row   = ROW_SEL(blk);
    assign blk_bit   = blk[bbas_pkg::BIT_W-1:0];
    assign free_bit  = bbas_pkg::first_free_bit(r_row_bits);
    assign grant_blk = bbas_pkg::BLK_W'({r_row_idx, free_bit});
    assign map_wr    = i_cmd.alloc || i_cmd.map_set || i_cmd.map_clr;

    always_comb begin
        n_row_bits = r_row_bits;
        n_used     = r_used;
        if (i_cmd.alloc) begin
            n_row_bits[free_bit] = 1'b1;
            n_used               = r_used + 1'b1;
        end else if (i_cmd.map_set) begin
            n_row_bits[blk_bit] = 1'b1;
            n_used              = r_used + 1'b1;
        end else if (i_cmd.map_clr) begin
            n_row_bits[blk_bit] = 1'b0;
            n_used              = r_used - 1'b1;
        end
    end

    assign free_cnt = bbas_pkg::CNT_W'(bbas_pkg::NUM_BLOCKS) - n_used;

    assign o_sts.req_valid = i_req.valid;
    assign o_sts.opcode    = r_opcode;
    assign o_sts.blk_ok    = 32'(r_block_number) < bbas_pkg::NUM_BLOCKS;
    assign o_sts.map_bit   = r_row_bits[blk_bit];
    assign o_sts.map_full  = &r_full;
    assign o_sts.last_word = (32'(r_word_cnt) == bbas_pkg::WORDS_PER_BLOCK - 1);
    assign o_sts.rsp_free  = rsp_free;

    // request beat
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_opcode       <= i_req.opcode;
            r_block_number <= i_req.block_number;
            r_word_index   <= i_req.word_index;
            r_write_word   <= i_req.write_word;
        end
    end

    // used map rows with full summary
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < bbas_pkg::MAP_ROWS; r++) begin
                r_map[r]  <= bbas_pkg::map_reset_row(r);
                r_full[r] <= &bbas_pkg::map_reset_row(r);
            end
            r_used <= bbas_pkg::CNT_W'(bbas_pkg::MAP_INIT_USED);
        end else begin
            if (map_wr) begin
                r_map[r_row_idx]  <= n_row_bits;
                r_full[r_row_idx] <= &n_row_bits;
            end
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_row_idx  <= i_cmd.lookup_free ? bbas_pkg::first_free_row(r_full) : blk_row;
            r_row_bits <= i_cmd.lookup_free ? r_map[bbas_pkg::first_free_row(r_full)]
                                            : r_map[blk_row];
        end
    end

    // block store
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[{blk, bbas_pkg::WORD_W'(r_word_index)}] <= r_write_word;
        end
        if (i_cmd.mem_rd) begin
            r_mem_q <= r_mem[{blk, r_word_cnt}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.word_clr) begin
            r_word_cnt <= '0;
        end else if (i_cmd.word_inc) begin
            r_word_cnt <= r_word_cnt + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.rsp_load) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rsp_load) begin
            r_rsp_status <= i_cmd.rsp_status;
            r_rsp_grant  <= i_cmd.rsp_grant ? bbas_pkg::GRANT_W'(grant_blk) : '0;
            r_rsp_word   <= i_cmd.rsp_data ? r_mem_q : '0;
            r_rsp_index  <= i_cmd.rsp_data ? bbas_pkg::RIDX_W'(r_word_cnt) : '0;
            r_rsp_last   <= i_cmd.rsp_last;
            r_rsp_used   <= bbas_pkg::COUNT_W'(n_used);
            r_rsp_free   <= bbas_pkg::COUNT_W'(free_cnt);
        end
    end

    assign o_rsp.valid         = r_rsp_valid;
    assign o_rsp.status        = r_rsp_status;
    assign o_rsp.granted_block = r_rsp_grant;
    assign o_rsp.read_word     = r_rsp_word;
    assign o_rsp.read_index    = r_rsp_index;
    assign o_rsp.last          = r_rsp_last;
    assign o_rsp.used_blocks   = r_rsp_used;
    assign o_rsp.free_blocks   = r_rsp_free;

`ifndef SYNTH
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= bbas_pkg::NUM_BLOCKS)
        else $error("used count beyond block count");

    a_alloc_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc |-> !(&r_full) && !r_row_bits[free_bit])
        else $error("allocate with no free block");

    a_set_clear_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.map_set |-> !r_row_bits[blk_bit])
        else $error("claim of a block already marked");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rsp_load |-> rsp_free)
        else $error("output register overwritten");

    a_full_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        map_wr |=> r_full[$past(r_row_idx)] == &r_map[$past(r_row_idx)])
        else $error("row summary out of step with map row");
`endif

endmodule

[design/bitmap_block_allocator_store.sv]
// top level of the bitmap block allocator store
// allocate, request, release, write and bad beats: lookup state, then the execute state loads the
// result into the output register once it is free; the next beat is taken back in idle
// read: four result beats, each read through the registered store port and then loaded
// into the output register; the next beat is taken after the last word has been loaded
// reset (synchronous): map blocks marked used, count set; store words undefined until written
`timescale 1ns / 1ps

module bitmap_block_allocator_store (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bbas_req_if.sink    i_req,
    bbas_rsp_if.source  o_rsp
);

    bbas_pkg::t_cmd cmd;
    bbas_pkg::t_sts sts;

    bbas_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bbas_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule

[sim/bbas_store_checker.sv]
// checker: mirrors the allocator map and store, predicts and compares result beats
`timescale 1ns / 1ps

module bbas_store_checker
    import bbas_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bbas_req_if  i_req,
    bbas_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_beats_checked,
    output int   o_full_replies
);

    localparam int MAX_PRINTED = 100;

    typedef struct {
        t_status             status;
        logic [GRANT_W-1:0]  grant;
        logic [DATA_W-1:0]   word;
        logic [RIDX_W-1:0]   index;
        logic                last;
        logic [COUNT_W-1:0]  used;
        logic [COUNT_W-1:0]  free;
    } t_reply;

    logic [NUM_BLOCKS-1:0] block_used;
    logic [COUNT_W-1:0]    blocks_in_use;
    logic [DATA_W-1:0]     word_store [MEM_DEPTH];
    t_reply                awaited_replies[$];
    int                    mismatches;
    int                    beats_checked;
    int                    full_replies;

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED) begin
            $display("mismatch at %0t ns: %s", $time, msg);
        end
        mismatches++;
    endtask

    task automatic restore_power_on_map();
        block_used = '0;
        for (int b = MAP_FIRST_BLOCK; b < MAP_FIRST_BLOCK + MAP_BLOCK_COUNT; b++) begin
            if (b < NUM_BLOCKS) block_used[b] = 1'b1;
        end
        blocks_in_use = COUNT_W'(MAP_INIT_USED);
        awaited_replies.delete();
    endtask

    task automatic queue_reply(input t_status st, input logic [GRANT_W-1:0] grant,
                               input logic [DATA_W-1:0] word, input logic [RIDX_W-1:0] index,
                               input logic last);
        t_reply r;
        r.status = st;
        r.grant  = grant;
        r.word   = word;
        r.index  = index;
        r.last   = last;
        r.used   = blocks_in_use;
        r.free   = COUNT_W'(NUM_BLOCKS) - blocks_in_use;
        awaited_replies.push_back(r);
    endtask

    task automatic predict_store_op(input logic [OPCODE_W-1:0] op,
                                    input logic [BLKNUM_W-1:0] blk,
                                    input logic [WIDX_W-1:0] widx,
                                    input logic [DATA_W-1:0] data);
        logic             blk_ok;
        logic             found;
        logic [BLK_W-1:0] b;
        blk_ok = blk < NUM_BLOCKS;
        b      = blk[BLK_W-1:0];
        found  = 1'b0;
        case (op)
            OP_ALLOC: begin
                for (int i = 0; i < NUM_BLOCKS; i++) begin
                    if (!found && !block_used[i]) begin
                        found         = 1'b1;
                        block_used[i] = 1'b1;
                        blocks_in_use = blocks_in_use + 1'b1;
                        queue_reply(ST_OK, GRANT_W'(i), '0, '0, 1'b1);
                    end
                end
                if (!found) queue_reply(ST_FULL, '0, '0, '0, 1'b1);
            end
            OP_REQUEST: begin
                if (!blk_ok) begin
                    queue_reply(ST_INVALID, '0, '0, '0, 1'b1);
                end else if (block_used[b]) begin
                    queue_reply(ST_USED, '0, '0, '0, 1'b1);
                end else begin
                    block_used[b] = 1'b1;
                    blocks_in_use = blocks_in_use + 1'b1;
                    queue_reply(ST_OK, '0, '0, '0, 1'b1);
                end
            end
            OP_RELEASE: begin
                if (!blk_ok) begin
                    queue_reply(ST_INVALID, '0, '0, '0, 1'b1);
                end else begin
                    if (block_used[b]) begin
                        block_used[b] = 1'b0;
                        blocks_in_use = blocks_in_use - 1'b1;
                    end
                    queue_reply(ST_OK, '0, '0, '0, 1'b1);
                end
            end
            OP_WRITE: begin
                if (!blk_ok) begin
                    queue_reply(ST_INVALID, '0, '0, '0, 1'b1);
                end else begin
                    word_store[{b, widx[WORD_W-1:0]}] = data;
                    queue_reply(ST_OK, '0, '0, '0, 1'b1);
                end
            end
            OP_READ: begin
                if (!blk_ok) begin
                    queue_reply(ST_INVALID, '0, '0, '0, 1'b1);
                end else begin
                    for (int w = 0; w < WORDS_PER_BLOCK; w++) begin
                        queue_reply(ST_OK, '0, word_store[{b, WORD_W'(w)}], RIDX_W'(w),
                                    w == WORDS_PER_BLOCK - 1);
                    end
                end
            end
            default: queue_reply(ST_INVALID, '0, '0, '0, 1'b1);
        endcase
    endtask

    task automatic compare_field(input string name, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
        end
    endtask

    task automatic check_reply();
        t_reply want;
        if (awaited_replies.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing outstanding, status %0d",
                                      i_rsp.status));
            return;
        end
        want = awaited_replies.pop_front();
        compare_field("status", DATA_W'(i_rsp.status), DATA_W'(want.status));
        compare_field("granted_block", DATA_W'(i_rsp.granted_block), DATA_W'(want.grant));
        compare_field("read_word", i_rsp.read_word, want.word);
        compare_field("read_index", DATA_W'(i_rsp.read_index), DATA_W'(want.index));
        compare_field("last", DATA_W'(i_rsp.last), DATA_W'(want.last));
        compare_field("used_blocks", DATA_W'(i_rsp.used_blocks), DATA_W'(want.used));
        compare_field("free_blocks", DATA_W'(i_rsp.free_blocks), DATA_W'(want.free));
        beats_checked++;
        if (want.status == ST_FULL) full_replies++;
    endtask

    initial begin
        mismatches    = 0;
        beats_checked = 0;
        full_replies  = 0;
        restore_power_on_map();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restore_power_on_map();
        end else begin
            if (i_rsp.valid && i_rsp.ready) check_reply();
            if (i_req.valid && i_req.ready) begin
                predict_store_op(i_req.opcode, i_req.block_number, i_req.word_index,
                                 i_req.write_word);
            end
        end
        o_pending       <= awaited_replies.size();
        o_fail_count    <= mismatches;
        o_beats_checked <= beats_checked;
        o_full_replies  <= full_replies;
    end

endmodule

[sim/tb_top.sv]
// testbench top: clock, reset, request stimulus, result stalls and verdict
`timescale 1ns / 1ps

module tb_top;
    import bbas_pkg::*;

    localparam int PHASE_ONE_ITEMS = 60;
    localparam int PHASE_TWO_ITEMS = 60;
    localparam int FINAL_ITEMS     = 60;
    localparam int ALLOC_BURST     = 16;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 24;
    localparam int MAX_GAP         = 40;
    localparam int BLKNUM_MAX      = (1 << BLKNUM_W) - 1;
    localparam logic [OPCODE_W-1:0] OP_LAST_CODE = '1;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bbas_req_if req_ch();
    bbas_rsp_if rsp_ch();

    int fail_count;
    int pending;
    int beats_checked;
    int full_replies;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_asks;
    int hold_taken;
    int hold_left;
    int quiet_cycles;
    int items_sent;

    bit word_written [MEM_DEPTH];
    bit block_readable [NUM_BLOCKS];
    int readable_blocks[$];

    bitmap_block_allocator_store u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    bbas_store_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (req_ch),
        .i_rsp           (rsp_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_beats_checked (beats_checked),
        .o_full_replies  (full_replies)
    );

    always #1 i_clk = ~i_clk;

    // result side stalls, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_asks != hold_taken) begin
            hold_taken = hold_asks;
            hold_left  = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (i_rst_n) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("no beat accepted for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic [DATA_W-1:0] random_data();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [BLKNUM_W-1:0] random_block();
        if ($urandom_range(99) < 85) return BLKNUM_W'($urandom_range(NUM_BLOCKS - 1));
        return BLKNUM_W'($urandom_range(BLKNUM_MAX, NUM_BLOCKS));
    endfunction

    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [BLKNUM_W-1:0] blk,
                             input logic [WIDX_W-1:0] widx, input logic [DATA_W-1:0] data);
        int  gap;
        bit  full_block;
        logic [BLK_W-1:0] b;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= op;
        req_ch.block_number <= blk;
        req_ch.word_index   <= widx;
        req_ch.write_word   <= data;
        do @(posedge i_clk); while (!req_ch.ready);
        items_sent++;
        if (op == OP_WRITE && blk < NUM_BLOCKS) begin
            b = blk[BLK_W-1:0];
            word_written[{b, widx[WORD_W-1:0]}] = 1'b1;
            full_block = 1'b1;
            for (int w = 0; w < WORDS_PER_BLOCK; w++) begin
                if (!word_written[{b, WORD_W'(w)}]) full_block = 1'b0;
            end
            if (full_block && !block_readable[b]) begin
                block_readable[b] = 1'b1;
                readable_blocks.push_back(int'(b));
            end
        end
    endtask

    task automatic fill_and_read(input logic [BLKNUM_W-1:0] blk);
        for (int w = 0; w < WORDS_PER_BLOCK; w++) begin
            send_item(OP_WRITE, blk, WIDX_W'(w), random_data());
        end
        if ($urandom_range(1)) send_item(OP_READ, blk, '0, random_data());
    endtask

    task automatic random_item();
        int pick;
        logic [BLKNUM_W-1:0] blk;
        pick = $urandom_range(99);
        blk  = random_block();
        if (pick < 25) begin
            fill_and_read(BLKNUM_W'($urandom_range(NUM_BLOCKS - 1)));
        end else if (pick < 40) begin
            send_item(OP_ALLOC, blk, WIDX_W'($urandom), random_data());
        end else if (pick < 52) begin
            send_item(OP_REQUEST, blk, WIDX_W'($urandom), random_data());
        end else if (pick < 66) begin
            send_item(OP_RELEASE, blk, WIDX_W'($urandom), random_data());
        end else if (pick < 78) begin
            send_item(OP_WRITE, blk, WIDX_W'($urandom), random_data());
        end else if (pick < 94) begin
            if (readable_blocks.size() > 0 && $urandom_range(99) < 85) begin
                blk = BLKNUM_W'(readable_blocks[$urandom_range(readable_blocks.size() - 1)]);
            end else begin
                blk = BLKNUM_W'($urandom_range(BLKNUM_MAX, NUM_BLOCKS));
            end
            send_item(OP_READ, blk, WIDX_W'($urandom), random_data());
        end else begin
            send_item(OPCODE_W'($urandom_range(OP_LAST_CODE, OP_READ + 1)), blk,
                      WIDX_W'($urandom), random_data());
        end
    endtask

    task automatic run_random(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) random_item();
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.opcode       = OP_ALLOC;
        req_ch.block_number = '0;
        req_ch.word_index   = '0;
        req_ch.write_word   = '0;
        rsp_ch.ready        = 1'b0;
        send_idle_pct       = 0;
        recv_idle_pct       = 0;
        hold_asks           = 0;
        hold_taken          = 0;
        hold_left           = 0;
        quiet_cycles        = 0;
        items_sent          = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: map blocks, extremes of block number and data, bad numbers, spare codes
        send_item(OP_ALLOC, '0, '0, '0);
        send_item(OP_REQUEST, BLKNUM_W'(MAP_FIRST_BLOCK), '0, '0);
        send_item(OP_REQUEST, BLKNUM_W'(NUM_BLOCKS - 1), '0, '0);
        send_item(OP_REQUEST, BLKNUM_W'(NUM_BLOCKS - 1), '0, '0);
        send_item(OP_REQUEST, BLKNUM_W'(BLKNUM_MAX), '0, '0);
        send_item(OP_RELEASE, BLKNUM_W'(MAP_FIRST_BLOCK), '0, '0);
        send_item(OP_RELEASE, BLKNUM_W'(MAP_FIRST_BLOCK), '0, '0);
        send_item(OP_RELEASE, BLKNUM_W'(NUM_BLOCKS), '0, '0);
        send_item(OP_ALLOC, '0, '0, '0);
        send_item(OP_WRITE, BLKNUM_W'(NUM_BLOCKS - 1), 2'd0, '1);
        send_item(OP_WRITE, BLKNUM_W'(NUM_BLOCKS - 1), 2'd1, '0);
        send_item(OP_WRITE, BLKNUM_W'(NUM_BLOCKS - 1), 2'd2, {32{2'b10}});
        send_item(OP_WRITE, BLKNUM_W'(NUM_BLOCKS - 1), 2'd3, {32{2'b01}});
        send_item(OP_READ, BLKNUM_W'(NUM_BLOCKS - 1), '0, '0);
        send_item(OP_WRITE, BLKNUM_W'(BLKNUM_MAX), 2'd3, '1);
        send_item(OP_READ, BLKNUM_W'(NUM_BLOCKS), '0, '0);
        for (int op = OP_READ + 1; op <= OP_LAST_CODE; op++) begin
            send_item(OPCODE_W'(op), BLKNUM_W'(NUM_BLOCKS - 1), '1, '1);
        end
        for (int w = WORDS_PER_BLOCK - 1; w >= 0; w--) begin
            send_item(OP_WRITE, '0, WIDX_W'(w), random_data());
        end
        send_item(OP_READ, '0, '0, '0);
        wait_drained();

        send_idle_pct = 28;
        recv_idle_pct = 84;
        run_random(PHASE_ONE_ITEMS);
        wait_drained();

        send_idle_pct = 84;
        recv_idle_pct = 28;
        run_random(PHASE_TWO_ITEMS);
        wait_drained();

        // full rate: long result hold-off during an allocate burst
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asks++;
        for (int n = 0; n < ALLOC_BURST; n++) begin
            send_item(OP_ALLOC, random_block(), WIDX_W'($urandom), random_data());
        end
        send_item(OP_REQUEST, BLKNUM_W'($urandom_range(NUM_BLOCKS - 1)), '0, '0);
        run_random(FINAL_ITEMS);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("drove %0d request beats through directed, stalled and full-rate phases",
                 items_sent);
        $display("checked %0d result beats, %0d of them store-full replies",
                 beats_checked, full_replies);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
design/bbas_pkg.sv
design/bbas_req_if.sv
design/bbas_rsp_if.sv
design/bbas_ctrl.sv
design/bbas_dp.sv
design/bitmap_block_allocator_store.sv
sim/bbas_store_checker.sv
sim/tb_top.sv
